/* sv/llv_pkg.sv */
// shared types and constants for the leaf light visibility table
`timescale 1ns / 1ps
package llv_pkg;

   localparam int WORD_BITS = 32;
   localparam int WORD_SHIFT = 5;
   localparam int LEAF_W = 10;
   localparam int WIDX_W = 5;
   localparam int LIGHT_W = 8;
   localparam int CNT_W = 11;

   typedef enum logic [2:0] {
      OP_LOAD_PVS  = 3'd0,
      OP_PLACE     = 3'd1,
      OP_FORGET    = 3'd2,
      OP_BEGIN     = 3'd3,
      OP_ADD_LEAF  = 3'd4,
      OP_NEXT      = 3'd5,
      OP_NOP       = 3'd6,
      OP_UNUSED    = 3'd7
   } op_type;

   typedef enum logic [3:0] {
      S_CLR,
      S_IDLE,
      S_HOME,
      S_SELF_RD,
      S_SELF_WR,
      S_PW_RD,
      S_PW_LD,
      S_J,
      S_J_WR,
      S_ADD,
      S_ADD_OR,
      S_SCAN,
      S_OUT
   } state_type;

   typedef struct packed {
      logic                accepted;
      logic                changed;
      logic                found;
      logic [LIGHT_W-1:0]  visible_light;
   } result_type;

endpackage

/* sv/llv_ram.sv */
// simple dual port synchronous ram, one write and one registered read
`timescale 1ns / 1ps
module llv_ram
   import llv_pkg::*;
#(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* sv/leaf_light_visibility_table.sv */
// top level: light placement over pvs rows and per-frame visible light scan
`timescale 1ns / 1ps
// Keeps light membership bits per leaf, loaded pvs rows and each light's home leaf, all in
// synchronous rams. After reset a clearing pass runs before the first item is taken; csr
// writes are taken meanwhile. One item is taken at a time; every item passes through the
// accept state S_IDLE and the output state S_OUT, and waits in S_OUT while the previous
// result has not been taken. Load pvs, begin frame, nop and the unused op go from accept
// straight to output. Forget homes sweeps the home ram. Add visible leaf reads the leaf row
// word by word and ORs it into the frame union. Next light tests one bit of the frame union
// per cycle. Place reads the light's home, then per walked region (old home, then new leaf)
// updates the light's own bit and, if that leaf's pvs row is loaded, does a read-modify-write
// of the membership ram for each leaf below leaf_count that the row marks visible.
module leaf_light_visibility_table
   import llv_pkg::*;
#(
   parameter int LIGHTS = 256,
   parameter int LEAVES = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // leaf_id[9:0], word_index[14:10], pvs_bits[46:15], pvs_present[47], light_id[55:48]
   input  logic [55:0] req_tdata,
   // op
   input  logic [2:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // accepted[0], changed[1], found[2], visible_light[10:3], zero fill
   output logic [15:0] rsp_tdata,
   input  logic        csr_we,
   input  logic [10:0] csr_wdata
);

   localparam int LWORDS = (LIGHTS + WORD_BITS - 1) / WORD_BITS;
   localparam int PWORDS = (LEAVES + WORD_BITS - 1) / WORD_BITS;
   localparam int BITS_D = LEAVES * LWORDS;
   localparam int PVS_D = LEAVES * PWORDS;
   localparam int BAW = $clog2(BITS_D);
   localparam int PAW = $clog2(PVS_D);
   localparam int VAW = $clog2(LEAVES);
   localparam int HAW = $clog2(LIGHTS);
   localparam int LW = $clog2(LEAVES + 1);
   localparam int CW = $clog2(LIGHTS + 1);
   localparam int LWB = (LWORDS > 1) ? $clog2(LWORDS) : 1;
   localparam int MAXD = (BITS_D > LIGHTS) ? BITS_D : LIGHTS;
   localparam int CLW = $clog2(MAXD + 1);
   localparam int HW = LEAF_W + 1;

   state_type state_ff, state_in;

   logic [CNT_W-1:0]   lc_ff;
   logic [LEAF_W-1:0]  leaf_ff, leaf_in;
   logic [LIGHT_W-1:0] light_ff, light_in;
   logic [LEAF_W-1:0]  rleaf_ff, rleaf_in;
   logic               set_ff, set_in;
   logic [LW-1:0]      j_ff, j_in;
   logic [WORD_BITS-1:0] pw_ff, pw_in;
   logic [LWB-1:0]     awc_ff, awc_in;
   logic [CW-1:0]      cursor_ff, cursor_in;
   logic [WORD_BITS-1:0] union_ff [LWORDS];
   logic [WORD_BITS-1:0] union_in [LWORDS];
   logic [CLW-1:0]     clr_ff, clr_in;
   logic               clr_all_ff, clr_all_in;
   result_type         res_ff, res_in;
   result_type         rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic               bits_we, pvs_we, pv_we, hm_we;
   logic [BAW-1:0]     bits_wa, bits_ra;
   logic [WORD_BITS-1:0] bits_wd, bits_rd;
   logic [PAW-1:0]     pvs_wa, pvs_ra;
   logic [WORD_BITS-1:0] pvs_wd, pvs_rd;
   logic [VAW-1:0]     pv_wa, pv_ra;
   logic               pv_wd, pv_rd;
   logic [HAW-1:0]     hm_wa, hm_ra;
   logic [HW-1:0]      hm_wd, hm_rd;

   op_type             op;
   logic [LEAF_W-1:0]  in_leaf;
   logic [WIDX_W-1:0]  in_widx;
   logic [WORD_BITS-1:0] in_bits;
   logic               in_present;
   logic [LIGHT_W-1:0] in_light;
   logic [31:0]        n32;
   logic [LW-1:0]      n_w;
   logic               leaf_ok;
   logic [BAW-1:0]     self_addr, j_addr, add_addr;
   logic [WORD_BITS-1:0] mask;
   logic [LW-1:0]      j_next;
   logic [CLW-1:0]     clr_last;

   assign op = op_type'(req_tuser);
   assign in_leaf = req_tdata[9:0];
   assign in_widx = req_tdata[14:10];
   assign in_bits = req_tdata[46:15];
   assign in_present = req_tdata[47];
   assign in_light = req_tdata[55:48];

   assign n32 = (32'(lc_ff) > 32'(LEAVES)) ? 32'(LEAVES) : 32'(lc_ff);
   assign n_w = LW'(n32);
   assign leaf_ok = 32'(in_leaf) < n32;

   assign self_addr = BAW'(32'(rleaf_ff) * LWORDS + 32'(light_ff >> WORD_SHIFT));
   assign j_addr = BAW'(32'(j_ff) * LWORDS + 32'(light_ff >> WORD_SHIFT));
   assign add_addr = BAW'(32'(leaf_ff) * LWORDS + 32'(awc_ff));
   assign mask = WORD_BITS'(1) << light_ff[WORD_SHIFT-1:0];
   assign j_next = j_ff + LW'(1);
   assign clr_last = clr_all_ff ? CLW'(MAXD - 1) : CLW'(LIGHTS - 1);

   llv_ram #(.WIDTH(WORD_BITS), .DEPTH(BITS_D)) u_bits (
      .clock(clock), .we(bits_we), .waddr(bits_wa), .wdata(bits_wd),
      .raddr(bits_ra), .rdata(bits_rd)
   );

   llv_ram #(.WIDTH(WORD_BITS), .DEPTH(PVS_D)) u_pvs (
      .clock(clock), .we(pvs_we), .waddr(pvs_wa), .wdata(pvs_wd),
      .raddr(pvs_ra), .rdata(pvs_rd)
   );

   llv_ram #(.WIDTH(1), .DEPTH(LEAVES)) u_pvs_valid (
      .clock(clock), .we(pv_we), .waddr(pv_wa), .wdata(pv_wd),
      .raddr(pv_ra), .rdata(pv_rd)
   );

   llv_ram #(.WIDTH(HW), .DEPTH(LIGHTS)) u_home (
      .clock(clock), .we(hm_we), .waddr(hm_wa), .wdata(hm_wd),
      .raddr(hm_ra), .rdata(hm_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR;
         lc_ff <= CNT_W'(1024);
         clr_ff <= '0;
         clr_all_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
         cursor_ff <= '0;
         for (int i = 0; i < LWORDS; i++) begin
            union_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            lc_ff <= csr_wdata;
         end
         clr_ff <= clr_in;
         clr_all_ff <= clr_all_in;
         rsp_valid_ff <= rsp_valid_in;
         cursor_ff <= cursor_in;
         union_ff <= union_in;
      end
      leaf_ff <= leaf_in;
      light_ff <= light_in;
      rleaf_ff <= rleaf_in;
      set_ff <= set_in;
      j_ff <= j_in;
      pw_ff <= pw_in;
      awc_ff <= awc_in;
      res_ff <= res_in;
      rsp_ff <= rsp_in;
   end

   always_comb begin
      state_in = state_ff;
      leaf_in = leaf_ff;
      light_in = light_ff;
      rleaf_in = rleaf_ff;
      set_in = set_ff;
      j_in = j_ff;
      pw_in = pw_ff;
      awc_in = awc_ff;
      cursor_in = cursor_ff;
      union_in = union_ff;
      clr_in = clr_ff;
      clr_all_in = clr_all_ff;
      res_in = res_ff;
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      req_tready = 1'b0;

      bits_we = 1'b0;
      bits_wa = self_addr;
      bits_wd = '0;
      bits_ra = self_addr;
      pvs_we = 1'b0;
      pvs_wa = PAW'(32'(in_leaf) * PWORDS + 32'(in_widx));
      pvs_wd = in_bits;
      pvs_ra = PAW'(32'(rleaf_ff) * PWORDS + 32'(j_ff >> WORD_SHIFT));
      pv_we = 1'b0;
      pv_wa = VAW'(in_leaf);
      pv_wd = in_present;
      pv_ra = VAW'(rleaf_ff);
      hm_we = 1'b0;
      hm_wa = HAW'(light_ff);
      hm_wd = {1'b1, leaf_ff};
      hm_ra = HAW'(in_light);

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_CLR: begin
            // clearing sweep: home, membership and pvs valid rams after reset, homes only on forget
            hm_wa = HAW'(clr_ff);
            hm_wd = '0;
            hm_we = 32'(clr_ff) < LIGHTS;
            bits_wa = BAW'(clr_ff);
            bits_we = clr_all_ff && (32'(clr_ff) < BITS_D);
            pv_wa = VAW'(clr_ff);
            pv_wd = 1'b0;
            pv_we = clr_all_ff && (32'(clr_ff) < LEAVES);
            clr_in = clr_ff + CLW'(1);
            if (clr_ff == clr_last) begin
               clr_in = '0;
               if (clr_all_ff) begin
                  clr_all_in = 1'b0;
                  state_in = S_IDLE;
               end else begin
                  state_in = S_OUT;
               end
            end
         end
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               leaf_in = in_leaf;
               light_in = in_light;
               res_in = '0;
               state_in = S_OUT;
               case (op)
                  OP_LOAD_PVS: begin
                     if (leaf_ok && (32'(in_widx) < PWORDS)) begin
                        pvs_we = in_present;
                        pv_we = 1'b1;
                        res_in.accepted = 1'b1;
                     end
                  end
                  OP_PLACE: begin
                     if (leaf_ok && (32'(in_light) < LIGHTS)) begin
                        res_in.accepted = 1'b1;
                        state_in = S_HOME;
                     end
                  end
                  OP_FORGET: begin
                     res_in.accepted = 1'b1;
                     clr_in = '0;
                     clr_all_in = 1'b0;
                     state_in = S_CLR;
                  end
                  OP_BEGIN: begin
                     res_in.accepted = 1'b1;
                     cursor_in = '0;
                     for (int i = 0; i < LWORDS; i++) begin
                        union_in[i] = '0;
                     end
                  end
                  OP_ADD_LEAF: begin
                     if (leaf_ok) begin
                        res_in.accepted = 1'b1;
                        awc_in = '0;
                        state_in = S_ADD;
                     end
                  end
                  OP_NEXT: begin
                     res_in.accepted = 1'b1;
                     state_in = S_SCAN;
                  end
                  OP_NOP: begin
                     res_in.accepted = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_HOME: begin
            if (hm_rd[HW-1] && (hm_rd[LEAF_W-1:0] == leaf_ff)) begin
               state_in = S_OUT;
            end else if (hm_rd[HW-1]) begin
               rleaf_in = hm_rd[LEAF_W-1:0];
               set_in = 1'b0;
               state_in = S_SELF_RD;
            end else begin
               rleaf_in = leaf_ff;
               set_in = 1'b1;
               state_in = S_SELF_RD;
            end
         end
         S_SELF_RD: begin
            bits_ra = self_addr;
            pv_ra = VAW'(rleaf_ff);
            state_in = S_SELF_WR;
         end
         S_SELF_WR: begin
            bits_we = 1'b1;
            bits_wa = self_addr;
            bits_wd = set_ff ? (bits_rd | mask) : (bits_rd & ~mask);
            j_in = '0;
            if (pv_rd && (n_w != '0)) begin
               state_in = S_PW_RD;
            end else if (!set_ff) begin
               rleaf_in = leaf_ff;
               set_in = 1'b1;
               state_in = S_SELF_RD;
            end else begin
               hm_we = 1'b1;
               res_in.changed = 1'b1;
               state_in = S_OUT;
            end
         end
         S_PW_RD: begin
            state_in = S_PW_LD;
         end
         S_PW_LD: begin
            pw_in = pvs_rd;
            state_in = S_J;
         end
         S_J, S_J_WR: begin
            bits_ra = j_addr;
            bits_wa = j_addr;
            bits_wd = set_ff ? (bits_rd | mask) : (bits_rd & ~mask);
            if ((state_ff == S_J) && pw_ff[j_ff[WORD_SHIFT-1:0]]) begin
               state_in = S_J_WR;
            end else begin
               bits_we = state_ff == S_J_WR;
               j_in = j_next;
               if (j_next == n_w) begin
                  // region walk done
                  if (!set_ff) begin
                     rleaf_in = leaf_ff;
                     set_in = 1'b1;
                     state_in = S_SELF_RD;
                  end else begin
                     hm_we = 1'b1;
                     res_in.changed = 1'b1;
                     state_in = S_OUT;
                  end
               end else if (j_next[WORD_SHIFT-1:0] == '0) begin
                  state_in = S_PW_RD;
               end else begin
                  state_in = S_J;
               end
            end
         end
         S_ADD: begin
            bits_ra = add_addr;
            state_in = S_ADD_OR;
         end
         S_ADD_OR: begin
            union_in[awc_ff] = union_ff[awc_ff] | bits_rd;
            awc_in = awc_ff + LWB'(1);
            if (32'(awc_ff) == LWORDS - 1) begin
               state_in = S_OUT;
            end else begin
               state_in = S_ADD;
            end
         end
         S_SCAN: begin
            if (32'(cursor_ff) >= LIGHTS) begin
               state_in = S_OUT;
            end else begin
               cursor_in = cursor_ff + CW'(1);
               if (union_ff[cursor_ff[WORD_SHIFT +: LWB]][cursor_ff[WORD_SHIFT-1:0]]) begin
                  res_in.found = 1'b1;
                  res_in.visible_light = cursor_ff[LIGHT_W-1:0];
                  state_in = S_OUT;
               end
            end
         end
         S_OUT: begin
            // result register frees up when empty or being drained this cycle
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_in = res_ff;
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {5'b0, rsp_ff.visible_light, rsp_ff.found, rsp_ff.changed,
                       rsp_ff.accepted};

endmodule
